// File: sv/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion unit
`default_nettype none
package rmq_pkg;

    localparam int ENT_W = 32;
    localparam int NUM_W = 33;
    localparam int Q_BITS = 33;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    localparam logic [31:0] OUT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] OUT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [1:0]            br;
        logic                  degen;
    } t_side;

    typedef struct packed {
        logic [1:0]  br;
        logic        degen;
        logic [31:0] major;
        logic [2:0]  neg;
        logic [2:0]  ovf;
    } t_tail;

    typedef struct packed {
        logic [31:0] q_w;
        logic [31:0] q_x;
        logic [31:0] q_y;
        logic [31:0] q_z;
        logic [1:0]  br;
        logic        degen;
    } t_res;

endpackage
`default_nettype wire

// File: sv/rmq_front.sv
// trace, branch select, square-root argument and off-diagonal numerators
`default_nettype none
module rmq_front #(
    parameter int FRAC_BITS = 30,
    parameter int AS = 36
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [8:0][rmq_pkg::ENT_W-1:0] i_ent,
    output logic                           o_valid,
    output logic [AS-2:0]                  o_arg,
    output rmq_pkg::t_side                 o_side
);
    import rmq_pkg::*;

    localparam logic [AS-1:0] ONE = {{(AS-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic                   r_v1;
    logic [8:0][ENT_W-1:0]  r_ent;
    logic signed [ENT_W+1:0] r_tr;
    logic                   r_c0;
    logic                   r_c1;

    logic signed [ENT_W+1:0] n_tr;
    logic signed [AS-1:0]   e00, e11, e22;
    logic signed [AS-1:0]   n_arg;
    logic signed [NUM_W-1:0] a01, a02, a10, a12, a20, a21;
    logic [1:0]             n_br;
    logic [2:0][NUM_W-1:0]  n_num;

    assign n_tr = (ENT_W+2)'($signed(i_ent[0])) + (ENT_W+2)'($signed(i_ent[4]))
                + (ENT_W+2)'($signed(i_ent[8]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_ent <= i_ent;
            r_tr  <= n_tr;
            r_c0  <= ($signed(i_ent[0]) > $signed(i_ent[4]))
                  && ($signed(i_ent[0]) > $signed(i_ent[8]));
            r_c1  <= $signed(i_ent[4]) > $signed(i_ent[8]);
        end
    end

    always_comb begin
        e00 = AS'($signed(r_ent[0]));
        e11 = AS'($signed(r_ent[4]));
        e22 = AS'($signed(r_ent[8]));
        a01 = NUM_W'($signed(r_ent[1]));
        a02 = NUM_W'($signed(r_ent[2]));
        a10 = NUM_W'($signed(r_ent[3]));
        a12 = NUM_W'($signed(r_ent[5]));
        a20 = NUM_W'($signed(r_ent[6]));
        a21 = NUM_W'($signed(r_ent[7]));
        if (r_tr > 0) begin
            n_br     = BR_TRACE;
            n_arg    = $signed(ONE) + e00 + e11 + e22;
            n_num[0] = a21 - a12;
            n_num[1] = a02 - a20;
            n_num[2] = a10 - a01;
        end else if (r_c0) begin
            n_br     = BR_X;
            n_arg    = $signed(ONE) + e00 - e11 - e22;
            n_num[0] = a21 - a12;
            n_num[1] = a01 + a10;
            n_num[2] = a02 + a20;
        end else if (r_c1) begin
            n_br     = BR_Y;
            n_arg    = $signed(ONE) + e11 - e00 - e22;
            n_num[0] = a02 - a20;
            n_num[1] = a01 + a10;
            n_num[2] = a12 + a21;
        end else begin
            n_br     = BR_Z;
            n_arg    = $signed(ONE) + e22 - e00 - e11;
            n_num[0] = a10 - a01;
            n_num[1] = a02 + a20;
            n_num[2] = a12 + a21;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
        if (i_en) begin
            o_side.num   <= n_num;
            o_side.br    <= n_br;
            o_side.degen <= n_arg <= 0;
            o_arg        <= (n_arg <= 0) ? '0 : n_arg[AS-2:0];
        end
    end

endmodule
`default_nettype wire

// File: sv/rmq_sqrt_step.sv
// one digit of the restoring square root
`default_nettype none
module rmq_sqrt_step #(
    parameter int RW = 32,
    parameter int SW = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [RW+1:0]  i_rem,
    input  wire logic [RW-1:0]  i_root,
    input  wire logic [SW-1:0]  i_v,
    input  rmq_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [RW+1:0]       o_rem,
    output logic [RW-1:0]       o_root,
    output logic [SW-1:0]       o_v,
    output rmq_pkg::t_side      o_side
);
    import rmq_pkg::*;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    assign rem_sh = {i_rem[RW-1:0], i_v[SW-1:SW-2]};
    assign trial  = {i_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_rem  <= ge ? rem_sh - trial : rem_sh;
            o_root <= {i_root[RW-2:0], ge};
            o_v    <= {i_v[SW-3:0], 2'b00};
            o_side <= i_side;
        end
    end

endmodule
`default_nettype wire

// File: sv/rmq_div_step.sv
// one quotient bit of three restoring dividers sharing a divisor
`default_nettype none
module rmq_div_step #(
    parameter int RW = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [RW-1:0]                i_d,
    input  wire logic [2:0][RW-1:0]           i_rem,
    input  wire logic [2:0][rmq_pkg::Q_BITS-1:0] i_nb,
    input  wire logic [2:0][rmq_pkg::Q_BITS-1:0] i_q,
    input  rmq_pkg::t_tail                    i_tail,
    output logic                              o_valid,
    output logic [RW-1:0]                     o_d,
    output logic [2:0][RW-1:0]                o_rem,
    output logic [2:0][rmq_pkg::Q_BITS-1:0]   o_nb,
    output logic [2:0][rmq_pkg::Q_BITS-1:0]   o_q,
    output rmq_pkg::t_tail                    o_tail
);
    import rmq_pkg::*;

    logic [2:0][RW:0]   rem_sh;
    logic [2:0]         ge;
    logic [2:0][RW-1:0] n_rem;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            rem_sh[l] = {i_rem[l], i_nb[l][Q_BITS-1]};
            ge[l]     = rem_sh[l] >= {1'b0, i_d};
            n_rem[l]  = ge[l] ? RW'(rem_sh[l] - {1'b0, i_d}) : rem_sh[l][RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_d    <= i_d;
            o_rem  <= n_rem;
            o_tail <= i_tail;
            for (int l = 0; l < 3; l++) begin
                o_nb[l] <= {i_nb[l][Q_BITS-2:0], 1'b0};
                o_q[l]  <= {i_q[l][Q_BITS-2:0], ge[l]};
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/rotation_matrix_to_quaternion_unit.sv
// top level: pipelined rotation matrix to unit quaternion conversion
// Converts one 3x3 rotation matrix (signed fixed point, FRAC_BITS fraction
// bits, Q1.30 by default) into the quaternion (w, x, y, z) by the
// four-branch trace method. A new matrix may enter every cycle while
// o_stall is low, and one quaternion leaves per cycle while i_stall is
// low. The pipeline is 2 front stages (trace and branch, then argument),
// RW square-root digit stages, where RW = ceil((max(FRAC_BITS,33) +
// FRAC_BITS)/2) is the root width, one divider setup stage, 33
// quotient-bit stages and the output register. The square-root depth
// grows with FRAC_BITS. All stages advance together; a skid
// register behind the output register absorbs one beat when the sink
// stalls, so o_stall is a plain register output. If the square-root
// argument is not positive the quaternion is all zeros and o_degenerate is
// set, with o_branch_taken still showing the selected branch.
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_r00,
    input  wire logic [31:0] i_r01,
    input  wire logic [31:0] i_r02,
    input  wire logic [31:0] i_r10,
    input  wire logic [31:0] i_r11,
    input  wire logic [31:0] i_r12,
    input  wire logic [31:0] i_r20,
    input  wire logic [31:0] i_r21,
    input  wire logic [31:0] i_r22,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_q_w,
    output logic [31:0]      o_q_x,
    output logic [31:0]      o_q_y,
    output logic [31:0]      o_q_z,
    output logic [1:0]       o_branch_taken,
    output logic             o_degenerate
);
    import rmq_pkg::*;

    // widths: signed argument, shifted radicand, root, compare, divisor
    localparam int K  = FRAC_BITS - 2;
    localparam int AS = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 3;
    localparam int AW = AS - 1;
    localparam int VW = AW + K;
    localparam int SW = VW + (VW % 2);
    localparam int RW = SW / 2;
    localparam int CW = (K > RW) ? K : RW;
    localparam int MW = (RW > 32) ? RW : 32;
    localparam int NW = NUM_W + K;

    // global advance: the whole pipe freezes only while the skid is full
    logic en;
    logic r_skid_valid;
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // front end
    logic [8:0][ENT_W-1:0] ent;
    logic                  f_valid;
    logic [AW-1:0]         f_arg;
    t_side                 f_side;

    assign ent = {i_r22, i_r21, i_r20, i_r12, i_r11, i_r10, i_r02, i_r01, i_r00};

    rmq_front #(.FRAC_BITS(FRAC_BITS), .AS(AS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ent   (ent),
        .o_valid (f_valid),
        .o_arg   (f_arg),
        .o_side  (f_side)
    );

    // square root of arg * 2^K, one digit per stage
    logic          s_valid [0:RW];
    logic [RW+1:0] s_rem   [0:RW];
    logic [RW-1:0] s_root  [0:RW];
    logic [SW-1:0] s_v     [0:RW];
    t_side         s_side  [0:RW];

    assign s_valid[0] = f_valid;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_v[0]     = SW'({f_arg, {K{1'b0}}});
    assign s_side[0]  = f_side;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        rmq_sqrt_step #(.RW(RW), .SW(SW)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_v     (s_v[g]),
            .i_side  (s_side[g]),
            .o_valid (s_valid[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_v     (s_v[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    // divider setup: magnitudes, overflow check on the top dividend bits
    logic [RW-1:0]           root;
    logic [MW-1:0]           root_ext;
    logic [2:0][NUM_W-1:0]   mag;
    logic [2:0][NW-1:0]      dvd;
    logic [2:0][CW-1:0]      hi_ext;
    logic [2:0]              n_ovf;
    logic [2:0]              n_neg;
    t_tail                   n_tail;

    assign root     = s_root[RW];
    assign root_ext = MW'(root);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_neg[l]  = s_side[RW].num[l][NUM_W-1];
            mag[l]    = n_neg[l] ? NUM_W'(0) - s_side[RW].num[l] : s_side[RW].num[l];
            dvd[l]    = {mag[l], {K{1'b0}}};
            hi_ext[l] = CW'(dvd[l][NW-1:Q_BITS]);
            n_ovf[l]  = hi_ext[l] >= CW'(root);
        end
        n_tail.br    = s_side[RW].br;
        n_tail.degen = s_side[RW].degen;
        n_tail.major = (root_ext > MW'(OUT_MAX)) ? OUT_MAX : root_ext[31:0];
        n_tail.neg   = n_neg;
        n_tail.ovf   = n_ovf;
    end

    logic                    d_valid [0:Q_BITS];
    logic [RW-1:0]           d_d     [0:Q_BITS];
    logic [2:0][RW-1:0]      d_rem   [0:Q_BITS];
    logic [2:0][Q_BITS-1:0]  d_nb    [0:Q_BITS];
    logic [2:0][Q_BITS-1:0]  d_q     [0:Q_BITS];
    t_tail                   d_tail  [0:Q_BITS];

    logic                    r_pre_valid;
    logic [RW-1:0]           r_pre_d;
    logic [2:0][RW-1:0]      r_pre_rem;
    logic [2:0][Q_BITS-1:0]  r_pre_nb;
    t_tail                   r_pre_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (en) begin
            r_pre_valid <= s_valid[RW];
        end
        if (en) begin
            r_pre_d    <= root;
            r_pre_tail <= n_tail;
            for (int l = 0; l < 3; l++) begin
                r_pre_rem[l] <= hi_ext[l][RW-1:0];
                r_pre_nb[l]  <= dvd[l][Q_BITS-1:0];
            end
        end
    end

    assign d_valid[0] = r_pre_valid;
    assign d_d[0]     = r_pre_d;
    assign d_rem[0]   = r_pre_rem;
    assign d_nb[0]    = r_pre_nb;
    assign d_q[0]     = '0;
    assign d_tail[0]  = r_pre_tail;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        rmq_div_step #(.RW(RW)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[g]),
            .i_d     (d_d[g]),
            .i_rem   (d_rem[g]),
            .i_nb    (d_nb[g]),
            .i_q     (d_q[g]),
            .i_tail  (d_tail[g]),
            .o_valid (d_valid[g+1]),
            .o_d     (d_d[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_nb    (d_nb[g+1]),
            .o_q     (d_q[g+1]),
            .o_tail  (d_tail[g+1])
        );
    end

    // saturate quotients, restore signs, place the major component
    logic [2:0][31:0] minor;
    t_tail            tl;
    t_res             res;

    assign tl = d_tail[Q_BITS];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (tl.neg[l]) begin
                minor[l] = (tl.ovf[l] || d_q[Q_BITS][l][Q_BITS-1:31] != 2'b00)
                         ? OUT_MIN : 32'(0) - d_q[Q_BITS][l][31:0];
            end else begin
                minor[l] = (tl.ovf[l] || d_q[Q_BITS][l][Q_BITS-1:31] != 2'b00)
                         ? OUT_MAX : d_q[Q_BITS][l][31:0];
            end
        end
        res.br    = tl.br;
        res.degen = tl.degen;
        unique case (tl.br)
            BR_TRACE: begin
                res.q_w = tl.major; res.q_x = minor[0];
                res.q_y = minor[1]; res.q_z = minor[2];
            end
            BR_X: begin
                res.q_w = minor[0]; res.q_x = tl.major;
                res.q_y = minor[1]; res.q_z = minor[2];
            end
            BR_Y: begin
                res.q_w = minor[0]; res.q_x = minor[1];
                res.q_y = tl.major; res.q_z = minor[2];
            end
            default: begin
                res.q_w = minor[0]; res.q_x = minor[1];
                res.q_y = minor[2]; res.q_z = tl.major;
            end
        endcase
        if (tl.degen) begin
            res.q_w = '0;
            res.q_x = '0;
            res.q_y = '0;
            res.q_z = '0;
        end
    end

    // output register plus one skid beat
    logic r_out_valid;
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (d_valid[Q_BITS]) begin
            if (!r_out_valid || !i_stall) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_q_w          = r_out.q_w;
    assign o_q_x          = r_out.q_x;
    assign o_q_y          = r_out.q_y;
    assign o_q_z          = r_out.q_z;
    assign o_branch_taken = r_out.br;
    assign o_degenerate   = r_out.degen;

`ifndef SYNTHESIS
    // a held skid beat always has a beat in front of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output is empty");

    // degenerate beats carry an all-zero quaternion
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_q_w == 32'd0 && o_q_x == 32'd0 && o_q_y == 32'd0 && o_q_z == 32'd0))
        else $error("degenerate beat with nonzero quaternion");

    // positive trace gives an argument above one, never degenerate
    a_trace_not_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_branch_taken == BR_TRACE) |-> (!o_degenerate && !o_q_w[31]))
        else $error("trace branch degenerate or negative scalar part");

    // a beat arriving at a stalled, full output fills the skid and raises o_stall
    a_stall_follows_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && !o_stall && $past(en) && d_valid[Q_BITS]) |=> o_stall)
        else $error("stalled output with arriving beat did not fill skid");
`endif

endmodule
`default_nettype wire

// File: verif/tb.sv
// testbench for the rotation matrix to quaternion unit: queued driver, checking monitor
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    typedef logic [8:0][31:0] t_mat;

    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG    = 4000;
    localparam int DRAIN       = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_mat        mat_r;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_q_w, o_q_x, o_q_y, o_q_z;
    logic [1:0]  o_branch_taken;
    logic        o_degenerate;

    rotation_matrix_to_quaternion_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_r00(mat_r[0]), .i_r01(mat_r[1]), .i_r02(mat_r[2]),
        .i_r10(mat_r[3]), .i_r11(mat_r[4]), .i_r12(mat_r[5]),
        .i_r20(mat_r[6]), .i_r21(mat_r[7]), .i_r22(mat_r[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_q_w(o_q_w), .o_q_x(o_q_x), .o_q_y(o_q_y), .o_q_z(o_q_z),
        .o_branch_taken(o_branch_taken), .o_degenerate(o_degenerate)
    );

    t_mat matrix_q[$];     // matrices waiting to be driven
    t_res quat_q[$];       // quaternions predicted for accepted matrices
    int   errors = 0;
    int   n_in = 0, n_out = 0, n_degen = 0;
    int   n_branch[4] = '{0, 0, 0, 0};
    int   mode = 0;        // 0: sender light idle, 1: receiver light idle, 2: no idling
    bit   hold_req = 0;
    bit   hold_done = 0;
    int   hold_left = 0;
    int   quiet = 0;

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // floor(sqrt(v)), v < 2^62
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned root, t;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if (t * t <= v) root = t;
        end
        return root;
    endfunction

    // num * 2^(FRAC-2) / den, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] minor_part(longint signed num, longint unsigned den);
        bit neg;
        longint unsigned mag, q;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        q = (mag << 28) / den;
        if (neg) begin
            if (q >= 64'h8000_0000) return OUT_MIN;
            return 32'(-longint'(q));
        end
        if (q > 64'h7fff_ffff) return OUT_MAX;
        return 32'(q);
    endfunction

    function automatic t_res quat_of(t_mat m);
        longint signed a[9];
        longint signed tr, arg, n0, n1, n2;
        longint unsigned major;
        logic [31:0] q[4];
        logic [31:0] mn[3];
        logic [1:0] br;
        int slot;
        t_res r;
        for (int i = 0; i < 9; i++) a[i] = longint'(signed'(m[i]));
        tr = a[0] + a[4] + a[8];
        if (tr > 0) begin
            br = BR_TRACE; arg = tr + (64'sd1 <<< 30);
            n0 = a[7] - a[5]; n1 = a[2] - a[6]; n2 = a[3] - a[1];
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            br = BR_X; arg = (64'sd1 <<< 30) + a[0] - a[4] - a[8];
            n0 = a[7] - a[5]; n1 = a[1] + a[3]; n2 = a[2] + a[6];
        end else if (a[4] > a[8]) begin
            br = BR_Y; arg = (64'sd1 <<< 30) + a[4] - a[0] - a[8];
            n0 = a[2] - a[6]; n1 = a[1] + a[3]; n2 = a[5] + a[7];
        end else begin
            br = BR_Z; arg = (64'sd1 <<< 30) + a[8] - a[0] - a[4];
            n0 = a[3] - a[1]; n1 = a[2] + a[6]; n2 = a[5] + a[7];
        end
        q = '{default: 32'd0};
        if (arg > 0) begin
            major = int_root(longint'(arg) << 28);
            mn[0] = minor_part(n0, major);
            mn[1] = minor_part(n1, major);
            mn[2] = minor_part(n2, major);
            q[br] = (major > 64'h7fff_ffff) ? OUT_MAX : 32'(major);
            slot = 0;
            for (int j = 0; j < 4; j++) begin
                if (j != int'(br)) begin
                    q[j] = mn[slot];
                    slot++;
                end
            end
        end
        r.q_w = q[0]; r.q_x = q[1]; r.q_y = q[2]; r.q_z = q[3];
        r.br = br;
        r.degen = (arg <= 0);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus generation
    // ---------------------------------------------------------------

    function automatic logic [31:0] fix(real v);
        real s;
        s = v * 1073741824.0;
        if (s > 1073741824.0) s = 1073741824.0;
        if (s < -1073741824.0) s = -1073741824.0;
        return 32'($rtoi(s));
    endfunction

    function automatic real rnd_unit();
        return ($itor($urandom_range(2000000)) - 1000000.0) / 1000000.0;
    endfunction

    // proper rotation from a random quaternion; small w steers toward branches 1 to 3
    function automatic t_mat rot_mat(bit flat_w);
        real w, x, y, z, n;
        t_mat m;
        w = rnd_unit(); x = rnd_unit(); y = rnd_unit(); z = rnd_unit();
        if (flat_w) w = w * 0.05;
        n = $sqrt(w * w + x * x + y * y + z * z);
        if (n < 1.0e-6) begin
            w = 1.0; n = 1.0;
        end
        w = w / n; x = x / n; y = y / n; z = z / n;
        m[0] = fix(1.0 - 2.0 * (y * y + z * z));
        m[1] = fix(2.0 * (x * y - z * w));
        m[2] = fix(2.0 * (x * z + y * w));
        m[3] = fix(2.0 * (x * y + z * w));
        m[4] = fix(1.0 - 2.0 * (x * x + z * z));
        m[5] = fix(2.0 * (y * z - x * w));
        m[6] = fix(2.0 * (x * z - y * w));
        m[7] = fix(2.0 * (y * z + x * w));
        m[8] = fix(1.0 - 2.0 * (x * x + y * y));
        return m;
    endfunction

    function automatic t_mat rnd_mat();
        t_mat m;
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return rot_mat(sel < 30);
        for (int i = 0; i < 9; i++) begin
            if (sel < 85) m[i] = 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
            else m[i] = $urandom;
        end
        // occasional diagonal ties
        if ($urandom_range(9) == 0) m[4] = m[0];
        if ($urandom_range(9) == 0) m[8] = m[4];
        return m;
    endfunction

    task automatic push_diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                             logic [31:0] off);
        t_mat m;
        m = {9{off}};
        m[0] = d0; m[4] = d1; m[8] = d2;
        matrix_q.insert(matrix_q.size(), m);
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++) matrix_q.insert(matrix_q.size(), rnd_mat());
    endtask

    // ---------------------------------------------------------------
    // driver: input beats from the pending queue
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                quat_q.insert(quat_q.size(), quat_of(mat_r));
                n_in++;
            end
            if (!i_valid || !o_stall) begin
                // light idling on the sender in mode 0, heavy in mode 1
                if ((mode == 0 && $urandom_range(99) < 10) ||
                    (mode == 1 && $urandom_range(99) < 55) ||
                    matrix_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    mat_r   <= matrix_q.pop_front();
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver stall: random per mode, plus one long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= (mode == 0 && $urandom_range(99) < 55) ||
                       (mode == 1 && $urandom_range(99) < 10);
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch beat %0d %s: got %h want %h", n_out, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // monitor: compare each output beat with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (quat_q.size() == 0) begin
                report_mismatch("unexpected beat", o_q_w, 32'd0);
            end else begin
                want = quat_q.pop_front();
                if (o_q_w !== want.q_w) report_mismatch("q_w", o_q_w, want.q_w);
                if (o_q_x !== want.q_x) report_mismatch("q_x", o_q_x, want.q_x);
                if (o_q_y !== want.q_y) report_mismatch("q_y", o_q_y, want.q_y);
                if (o_q_z !== want.q_z) report_mismatch("q_z", o_q_z, want.q_z);
                if (o_branch_taken !== want.br)
                    report_mismatch("branch", 32'(o_branch_taken), 32'(want.br));
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", 32'(o_degenerate), 32'(want.degen));
                n_branch[want.br]++;
                if (want.degen) n_degen++;
            end
            n_out++;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG);
            $display("FAIL rotation_matrix_to_quaternion_unit");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        mat_r   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, half turns about each axis, ties, extremes
        push_diag(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0);
        push_diag(32'h4000_0000, 32'hc000_0000, 32'hc000_0000, 32'h0);
        push_diag(32'hc000_0000, 32'h4000_0000, 32'hc000_0000, 32'h0);
        push_diag(32'hc000_0000, 32'hc000_0000, 32'h4000_0000, 32'h0);
        push_diag(32'h0, 32'h0, 32'h0, 32'h0);
        push_diag(32'hc000_0000, 32'hc000_0000, 32'hc000_0000, 32'h4000_0000);
        push_diag(32'h4000_0000, 32'h4000_0000, 32'hc000_0000, 32'hc000_0000);
        push_diag(32'h2000_0000, 32'hc000_0000, 32'h2000_0000, 32'h1234_5678);
        push_diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        push_diag(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        push_diag(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        push_diag(32'hc000_0000, 32'h0000_0001, 32'h0000_0000, 32'h4000_0000);
        push_diag(32'hbfff_ffff, 32'hc000_0000, 32'h4000_0000, 32'hc000_0000);
        push_diag(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
        push_diag(32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff, 32'h4000_0000);
        push_diag(32'hc000_0000, 32'hc000_0001, 32'h7fff_ffff, 32'h8000_0000);
        for (int i = 0; i < 6; i++) matrix_q.insert(matrix_q.size(), rot_mat(i[0]));
        push_random(600);
        wait (matrix_q.size() == 0);
        // sender pause until every prediction has been matched
        wait (quat_q.size() == 0 && !i_valid);
        repeat (5) @(posedge i_clk);

        mode = 1;
        push_random(575);
        wait (matrix_q.size() == 0);

        // long hold-off on the output while the sender keeps pushing
        mode = 2;
        push_random(550);
        hold_req = 1'b1;
        wait (matrix_q.size() == 0);
        wait (quat_q.size() == 0 && !i_valid && hold_left == 0);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d matrices in, %0d quaternions out, %0d degenerate",
                 n_in, n_out, n_degen);
        $display("branches trace/x/y/z: %0d %0d %0d %0d, with a %0d cycle output hold",
                 n_branch[0], n_branch[1], n_branch[2], n_branch[3], HOLD_CYCLES);
        if (errors == 0 && quat_q.size() == 0) begin
            $display("PASS rotation_matrix_to_quaternion_unit");
        end else begin
            $display("FAIL rotation_matrix_to_quaternion_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire
